[rtl/core/mep_pkg.sv]
// Shared types and constants for the Mandelbrot escape-time pixel block.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package mep_pkg;

  // Defaults for the top-level parameters
  localparam int GRAY_LEVELS_DEF     = 256;
  localparam int COORD_FRAC_BITS_DEF = 28;
  localparam int INDEX_BITS_DEF      = 12;

  // Fixed field widths
  localparam int IDX_FIELD_W = 12;
  localparam int COORD_W     = 32;
  localparam int STEP_W      = 29;
  localparam int ITER_W      = 16;
  localparam int GRAY_W      = 8;
  localparam int APB_ADDR_W  = 5;
  localparam int APB_DATA_W  = 32;

  // Gray search carries, sized for the largest level count
  localparam int GM_W  = GRAY_W + ITER_W;
  localparam int SQM_W = 2 * GRAY_W + ITER_W;

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_X_MIN    = 3'd0,
    REG_Y_MIN    = 3'd1,
    REG_X_STEP   = 3'd2,
    REG_Y_STEP   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_e;

  localparam logic signed [COORD_W-1:0] X_MIN_RST    = -32'sd536870912;
  localparam logic signed [COORD_W-1:0] Y_MIN_RST    = -32'sd536870912;
  localparam logic [STEP_W-1:0]         X_STEP_RST   = 29'd355073;
  localparam logic [STEP_W-1:0]         Y_STEP_RST   = 29'd568117;
  localparam logic [ITER_W-1:0]         MAX_ITER_RST = 16'd256;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_min;
    logic signed [COORD_W-1:0] y_min;
    logic [STEP_W-1:0]         x_step;
    logic [STEP_W-1:0]         y_step;
    logic [ITER_W-1:0]         max_iter;
  } cfg_t;

  typedef struct packed {
    logic [IDX_FIELD_W-1:0] col;
    logic [IDX_FIELD_W-1:0] row;
  } pix_in_t;

  typedef struct packed {
    logic [GRAY_W-1:0] gray;
    logic [ITER_W-1:0] step_count;
  } pix_out_t;

  // Iteration unit result, one-cycle pulse
  typedef struct packed {
    logic              valid;
    logic [ITER_W-1:0] count;
  } iter_res_t;

  // Token passed along the gray search chain
  typedef struct packed {
    logic              valid;
    logic [GRAY_W-1:0] g;     // gray decided so far
    logic [GM_W-1:0]   gm;    // g * max_iter
    logic [SQM_W-1:0]  gsqm;  // g * g * max_iter
    logic [ITER_W-1:0] m;     // max_iter
    logic [SQM_W-1:0]  rhs;   // step_count * (levels-1)^2
  } gray_tok_t;

endpackage

[rtl/core/mep_cfg.sv]
// Configuration register file behind an APB-style slave port.
// Depends on mep_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module mep_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic [mep_pkg::APB_ADDR_W-1:0]  paddr_i,
  input  logic [mep_pkg::APB_DATA_W-1:0]  pwdata_i,
  output logic [mep_pkg::APB_DATA_W-1:0]  prdata_o,
  output logic                            pready_o,
  output mep_pkg::cfg_t                   cfg_o
);
  import mep_pkg::*;

  cfg_t     cfg_q;
  logic     wr_en;
  reg_idx_e idx;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign idx      = reg_idx_e'(paddr_i[APB_ADDR_W-1:2]);
  assign cfg_o    = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.x_min    <= X_MIN_RST;
      cfg_q.y_min    <= Y_MIN_RST;
      cfg_q.x_step   <= X_STEP_RST;
      cfg_q.y_step   <= Y_STEP_RST;
      cfg_q.max_iter <= MAX_ITER_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_X_MIN:    cfg_q.x_min    <= $signed(pwdata_i);
        REG_Y_MIN:    cfg_q.y_min    <= $signed(pwdata_i);
        REG_X_STEP:   cfg_q.x_step   <= pwdata_i[STEP_W-1:0];
        REG_Y_STEP:   cfg_q.y_step   <= pwdata_i[STEP_W-1:0];
        REG_MAX_ITER: cfg_q.max_iter <= pwdata_i[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata_o = '0;
    unique case (idx)
      REG_X_MIN:    prdata_o = cfg_q.x_min;
      REG_Y_MIN:    prdata_o = cfg_q.y_min;
      REG_X_STEP:   prdata_o = APB_DATA_W'(cfg_q.x_step);
      REG_Y_STEP:   prdata_o = APB_DATA_W'(cfg_q.y_step);
      REG_MAX_ITER: prdata_o = APB_DATA_W'(cfg_q.max_iter);
      default:      prdata_o = '0;
    endcase
  end

endmodule

[rtl/core/mep_iter.sv]
// Escape-time iteration unit: coordinate mapping, complex square and escape test.
// Depends on mep_pkg for cfg_t and iter_res_t.
`timescale 1ns / 1ps

module mep_iter #(
  parameter int COORD_FRAC_BITS = mep_pkg::COORD_FRAC_BITS_DEF,
  parameter int INDEX_BITS      = mep_pkg::INDEX_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [INDEX_BITS-1:0] col_i,
  input  logic [INDEX_BITS-1:0] row_i,
  input  mep_pkg::cfg_t         cfg_i,
  output mep_pkg::iter_res_t    res_o
);
  import mep_pkg::*;

  localparam int PW = INDEX_BITS + STEP_W;  // index * step
  localparam int CW = PW + 2;               // min + index * step
  localparam int NW = 2 * COORD_W + 2;      // one update before the escape test

  localparam logic signed [NW-1:0] TWO     = NW'(2) <<< COORD_FRAC_BITS;
  localparam logic signed [NW-1:0] NEG_TWO = -TWO;
  localparam logic [2*COORD_W-1:0] FOUR_SQ = (2*COORD_W)'(4) << (2 * COORD_FRAC_BITS);

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_MUL  = 3'b010,
    PH_ADD  = 3'b100
  } phase_e;

  function automatic logic signed [COORD_W-1:0] sat_c(input logic signed [CW-1:0] v);
    logic [CW-COORD_W:0] top;
    logic signed [COORD_W-1:0] r;
    top = v[CW-1:COORD_W-1];
    if (top == '0 || top == '1) begin
      r = v[COORD_W-1:0];
    end else if (v[CW-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

  phase_e phase_q, phase_d;
  logic   done_q, done_d;
  logic   upd;

  logic [PW-1:0]               prod_x, prod_y;
  logic signed [CW-1:0]        cr_full, ci_full;
  logic signed [COORD_W-1:0]   cr_c, ci_c;
  logic signed [COORD_W-1:0]   cr_q, ci_q, zr_q, zi_q;
  logic signed [2*COORD_W-1:0] sqr_q, sqi_q, crs_q;
  logic signed [2*COORD_W-1:0] diff, diff_sh, crs_sh;
  logic [2*COORD_W-1:0]        sqsum;
  logic signed [NW-1:0]        nr, ni;
  logic [ITER_W-1:0]           count_q, res_count_q, res_count_d;
  logic [ITER_W:0]             count_inc;
  logic                        first_q;
  logic                        esc_sq, esc_abs, at_limit;

  // c = min + index * step, saturated to 32 bits
  assign prod_x  = col_i * cfg_i.x_step;
  assign prod_y  = row_i * cfg_i.y_step;
  assign cr_full = CW'(cfg_i.x_min) + $signed({2'b00, prod_x});
  assign ci_full = CW'(cfg_i.y_min) + $signed({2'b00, prod_y});
  assign cr_c    = sat_c(cr_full);
  assign ci_c    = sat_c(ci_full);

  // z' = z^2 + c, floor shifts
  assign diff    = sqr_q - sqi_q;
  assign diff_sh = diff >>> COORD_FRAC_BITS;
  assign crs_sh  = crs_q >>> (COORD_FRAC_BITS - 1);
  assign nr      = NW'(diff_sh) + NW'(cr_q);
  assign ni      = NW'(crs_sh) + NW'(ci_q);

  // squares of the held z finish the escape test of the previous update
  assign sqsum     = sqr_q + sqi_q;
  assign esc_sq    = !first_q && (sqsum >= FOUR_SQ);
  assign esc_abs   = (nr >= TWO) || (nr <= NEG_TWO) || (ni >= TWO) || (ni <= NEG_TWO);
  assign count_inc = {1'b0, count_q} + (ITER_W+1)'(1);
  assign at_limit  = count_inc >= {1'b0, cfg_i.max_iter};

  always_comb begin
    phase_d     = phase_q;
    done_d      = 1'b0;
    upd         = 1'b0;
    res_count_d = count_q;
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) phase_d = PH_MUL;
      end
      PH_MUL: begin
        phase_d = PH_ADD;
      end
      PH_ADD: begin
        if (esc_sq || at_limit) begin
          done_d  = 1'b1;
          phase_d = PH_IDLE;
        end else if (esc_abs) begin
          done_d      = 1'b1;
          res_count_d = count_inc[ITER_W-1:0];
          phase_d     = PH_IDLE;
        end else begin
          upd     = 1'b1;
          phase_d = PH_MUL;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && start_i) begin
      cr_q    <= cr_c;
      ci_q    <= ci_c;
      zr_q    <= cr_c;
      zi_q    <= ci_c;
      count_q <= '0;
      first_q <= 1'b1;
    end
    if (phase_q == PH_MUL) begin
      sqr_q <= zr_q * zr_q;
      sqi_q <= zi_q * zi_q;
      crs_q <= zr_q * zi_q;
    end
    // not escaped, so both parts lie within (-2, 2) and fit the coordinate width
    if (upd) begin
      zr_q    <= nr[COORD_W-1:0];
      zi_q    <= ni[COORD_W-1:0];
      count_q <= count_inc[ITER_W-1:0];
      first_q <= 1'b0;
    end
    if (done_d) res_count_q <= res_count_d;
  end

  assign res_o.valid = done_q;
  assign res_o.count = res_count_q;

endmodule

[rtl/core/mep_gray_cell.sv]
// One cell of the gray search chain: settles one bit of the gray level.
// Depends on mep_pkg for gray_tok_t and field widths.
`timescale 1ns / 1ps

module mep_gray_cell #(
  parameter int GRAY_LEVELS = mep_pkg::GRAY_LEVELS_DEF,
  parameter int BIT         = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mep_pkg::gray_tok_t tok_i,
  output mep_pkg::gray_tok_t tok_o
);
  import mep_pkg::*;

  localparam logic [GRAY_W-1:0] BITV = GRAY_W'(1) << BIT;
  localparam logic [GRAY_W-1:0] TOP  = GRAY_W'(GRAY_LEVELS - 1);

  gray_tok_t        tok_q, tok_d;
  logic [GRAY_W-1:0] trial;
  logic [SQM_W-1:0]  trial_sqm;
  logic              take;

  // (g + b)^2 * m = g^2 m + 2 b g m + b^2 m, b a power of two
  assign trial     = tok_i.g | BITV;
  assign trial_sqm = tok_i.gsqm + (SQM_W'(tok_i.gm) << (BIT + 1))
                   + (SQM_W'(tok_i.m) << (2 * BIT));
  assign take      = (trial <= TOP) && (trial_sqm <= tok_i.rhs);

  always_comb begin
    tok_d = tok_i;
    if (take) begin
      tok_d.g    = trial;
      tok_d.gm   = tok_i.gm + (GM_W'(tok_i.m) << BIT);
      tok_d.gsqm = trial_sqm;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

[rtl/core/mandelbrot_escape_pixel.sv]
// Top level of the Mandelbrot escape-time pixel block.
// Depends on mep_pkg, mep_cfg, mep_iter and mep_gray_cell.
//
//  channel   direction  handshake                 payload
//  --------  ---------  ------------------------  -------------------------------
//  pixel in  in         in_valid_i / in_stall_o   in_data_i  {col, row}
//  result    out        out_valid_o / out_stall_i out_data_o {gray, step_count}
//  config    in/out     psel/penable/pwrite       paddr, pwdata, prdata (pready=1)
//
// Flow: one pixel at a time. Each z update passes through the complex square unit,
// first a multiply phase (three 32x32 products), then an add and escape test phase.
// A run ends on the magnitude bound, on the square test or on the iteration limit;
// GRAY_BITS is the length of the gray search chain, one bit settled per cell.
// The next pixel can transfer in the cycle after the result is loaded.
// Reset: asynchronous, active low; config and control registers reset to defaults.
// Stalls: a finished result waits in the output register while the next pixel
// is taken and iterated; a new pixel is refused only while one is in flight.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel #(
  parameter int GRAY_LEVELS     = mep_pkg::GRAY_LEVELS_DEF,
  parameter int COORD_FRAC_BITS = mep_pkg::COORD_FRAC_BITS_DEF,
  parameter int INDEX_BITS      = mep_pkg::INDEX_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // pixel in
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  mep_pkg::pix_in_t               in_data_i,
  // result out
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output mep_pkg::pix_out_t              out_data_o,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mep_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mep_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mep_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import mep_pkg::*;

  localparam int GRAY_BITS = $clog2(GRAY_LEVELS);
  localparam logic [SQM_W-1:0] LEVEL_SQ = SQM_W'((GRAY_LEVELS - 1) * (GRAY_LEVELS - 1));

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // ready for a pixel
    ST_ITER = 4'b0010,  // iteration unit busy
    ST_GRAY = 4'b0100,  // token walking the gray chain
    ST_HOLD = 4'b1000   // waiting for the output register
  } state_e;

  state_e    state_q, state_d;
  cfg_t      cfg;
  iter_res_t iter_res;
  gray_tok_t chain [GRAY_BITS+1];

  logic              accept, load;
  logic              launch_q, launch_d;
  logic [ITER_W-1:0] count_q;
  logic [SQM_W-1:0]  rhs_q;
  logic [GRAY_W-1:0] gray_q;
  logic              out_valid_q;
  pix_out_t          out_q;

  // ---------------------------------------------------------------- config
  mep_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // -------------------------------------------------------- iteration unit
  // Only the low INDEX_BITS of each index take part in the mapping.
  mep_iter #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .INDEX_BITS      (INDEX_BITS)
  ) u_iter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .col_i   (in_data_i.col[INDEX_BITS-1:0]),
    .row_i   (in_data_i.row[INDEX_BITS-1:0]),
    .cfg_i   (cfg),
    .res_o   (iter_res)
  );

  // ------------------------------------------------------ gray search chain
  // Largest g with g*g*max_iter <= count*(levels-1)^2, MSB first, one bit a cell.
  assign chain[0].valid = launch_q;
  assign chain[0].g     = '0;
  assign chain[0].gm    = '0;
  assign chain[0].gsqm  = '0;
  assign chain[0].m     = cfg.max_iter;
  assign chain[0].rhs   = rhs_q;

  for (genvar i = 0; i < GRAY_BITS; i++) begin : g_cell
    mep_gray_cell #(
      .GRAY_LEVELS (GRAY_LEVELS),
      .BIT         (GRAY_BITS - 1 - i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  // --------------------------------------------------------------- control
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = (state_q == ST_HOLD) && (!out_valid_q || !out_stall_i);
  assign launch_d   = (state_q == ST_ITER) && iter_res.valid;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept)              state_d = ST_ITER;
      ST_ITER: if (iter_res.valid)      state_d = ST_GRAY;
      ST_GRAY: if (chain[GRAY_BITS].valid) state_d = ST_HOLD;
      ST_HOLD: if (load)                state_d = ST_IDLE;
      default:                          state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= launch_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch_d) begin
      count_q <= iter_res.count;
      rhs_q   <= SQM_W'(iter_res.count) * LEVEL_SQ;
    end
    // a zero limit gives black whatever the chain settles on
    if (state_q == ST_GRAY && chain[GRAY_BITS].valid) begin
      gray_q <= (cfg.max_iter == '0) ? '0 : chain[GRAY_BITS].g;
    end
    if (load) begin
      out_q.gray       <= gray_q;
      out_q.step_count <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ------------------------------------------------------------ assertions
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_ITER)
    else $error("pixel transfer did not start the iteration unit");

  a_iter_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_res.valid |-> state_q == ST_ITER)
    else $error("iteration result outside the iterate state");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_res.valid |-> (iter_res.count < cfg.max_iter) || (iter_res.count == '0))
    else $error("step count beyond the iteration limit");

  a_chain_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[GRAY_BITS].valid |-> state_q == ST_GRAY)
    else $error("gray chain result outside the gray state");

endmodule
